// ----- rtl/sparse_table_range_min_macros.svh -----
// Assertion macros shared by the range-minimum modules.
`ifndef SPARSE_TABLE_RANGE_MIN_MACROS_SVH
`define SPARSE_TABLE_RANGE_MIN_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STRMQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("strmq assertion failed");

// Next-cycle implication, checked outside reset.
`define STRMQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("strmq assertion failed");

`endif

// ----- rtl/strmq_pkg.sv -----
// Shared constants, codes and controller/datapath interface types.
package strmq_pkg;

    // Table geometry.
    localparam int MAX_ELEMENTS = 1024;
    localparam int LEVELS       = 11;
    localparam int DATA_W       = 64;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int LVL_W        = $clog2(LEVELS);
    localparam int ADDR_W       = LVL_W + IDX_W;
    localparam int MEM_DEPTH    = LEVELS * MAX_ELEMENTS;
    localparam int K_W          = $clog2(CNT_W);
    localparam int WIN_W        = ((CNT_W > LEVELS) ? CNT_W : LEVELS) + 1;

    // Field widths on the streams.
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;
    localparam int S_TDATA_W    = ((DATA_W + IDX_W + CNT_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((DATA_W + CNT_W + 7) / 8) * 8;

    // Operation codes of a request.
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_RANGE = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_APPEND,
        S_QCMP,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    res_set;
        t_status res_status;
        logic    app_write;
        logic    qry_read;
        logic    qry_cmp;
        logic    clear;
        logic    load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            bad;
        logic            app_last;
    } t_sts;

endpackage

// ----- rtl/strmq_dp.sv -----
// Datapath: level store, append and query address logic, result registers.
`include "sparse_table_range_min_macros.svh"

module strmq_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  strmq_pkg::t_cmd                     i_cmd,
    output strmq_pkg::t_sts                     o_sts,
    input  logic [strmq_pkg::OP_W-1:0]          i_op,
    input  logic signed [strmq_pkg::DATA_W-1:0] i_value,
    input  logic [strmq_pkg::IDX_W-1:0]         i_left,
    input  logic [strmq_pkg::CNT_W-1:0]         i_right,
    output logic signed [strmq_pkg::DATA_W-1:0] o_minimum,
    output logic [strmq_pkg::STATUS_W-1:0]      o_status,
    output logic [strmq_pkg::CNT_W-1:0]         o_count
);

    // Floor of log2 for a nonzero range length.
    function automatic logic [strmq_pkg::K_W-1:0] top_bit(
        input logic [strmq_pkg::CNT_W-1:0] x
    );
        logic [strmq_pkg::K_W-1:0] k;
        k = '0;
        for (int i = 0; i < strmq_pkg::CNT_W; i++) begin
            if (x[i]) begin
                k = strmq_pkg::K_W'(i);
            end
        end
        return k;
    endfunction

    logic signed [strmq_pkg::DATA_W-1:0] mem [0:strmq_pkg::MEM_DEPTH-1];

    logic [strmq_pkg::OP_W-1:0]          r_op;
    logic signed [strmq_pkg::DATA_W-1:0] r_value;
    logic [strmq_pkg::IDX_W-1:0]         r_left;
    logic [strmq_pkg::CNT_W-1:0]         r_right;
    logic [strmq_pkg::CNT_W-1:0]         r_count;
    logic [strmq_pkg::LVL_W-1:0]         r_level;
    logic signed [strmq_pkg::DATA_W-1:0] r_last;
    logic signed [strmq_pkg::DATA_W-1:0] r_rd_a;
    logic signed [strmq_pkg::DATA_W-1:0] r_rd_b;
    logic signed [strmq_pkg::DATA_W-1:0] r_res_min;
    strmq_pkg::t_status                  r_res_status;
    logic signed [strmq_pkg::DATA_W-1:0] r_out_min;
    strmq_pkg::t_status                  r_out_status;
    logic [strmq_pkg::CNT_W-1:0]         r_out_count;

    logic [strmq_pkg::CNT_W-1:0]         p_plus;
    logic [strmq_pkg::LVL_W:0]           lvl_next;
    logic [strmq_pkg::WIN_W-1:0]         win_cur;
    logic [strmq_pkg::WIN_W-1:0]         win_next;
    logic [strmq_pkg::WIN_W-1:0]         s_cur;
    logic [strmq_pkg::WIN_W-1:0]         s_next;
    logic                                app_last;
    logic signed [strmq_pkg::DATA_W-1:0] wr_data;
    logic [strmq_pkg::ADDR_W-1:0]        wr_addr;
    logic [strmq_pkg::ADDR_W-1:0]        addr_a;
    logic [strmq_pkg::ADDR_W-1:0]        addr_b;
    logic                                rd_a_en;
    logic [strmq_pkg::CNT_W-1:0]         left_ext;
    logic [strmq_pkg::CNT_W-1:0]         q_len;
    logic [strmq_pkg::K_W-1:0]           q_k;
    logic [strmq_pkg::CNT_W-1:0]         q_second;
    logic                                q_bad;

    // Append: the level being written ends its window at the new element.
    always_comb begin
        p_plus   = r_count + strmq_pkg::CNT_W'(1);
        lvl_next = {1'b0, r_level} + (strmq_pkg::LVL_W + 1)'(1);
        win_cur  = strmq_pkg::WIN_W'(1) << r_level;
        win_next = strmq_pkg::WIN_W'(1) << lvl_next;
        s_cur    = strmq_pkg::WIN_W'(p_plus) - win_cur;
        s_next   = strmq_pkg::WIN_W'(p_plus) - win_next;
        app_last = (int'(lvl_next) == strmq_pkg::LEVELS)
                || (strmq_pkg::WIN_W'(p_plus) < win_next);
        // Level 0 takes the new value; higher levels merge two halves, the upper
        // half being the last entry written.
        if (r_level == '0) begin
            wr_data = r_value;
        end else begin
            wr_data = (r_last < r_rd_a) ? r_last : r_rd_a;
        end
        wr_addr = {r_level, s_cur[strmq_pkg::IDX_W-1:0]};
    end

    // Query: range check, level and the two window starts.
    always_comb begin
        left_ext = strmq_pkg::CNT_W'(r_left);
        q_len    = r_right - left_ext;
        q_k      = top_bit(q_len);
        q_second = r_right - (strmq_pkg::CNT_W'(1) << q_k);
        q_bad    = (left_ext >= r_right) || (r_right > r_count)
                || (int'(q_k) >= strmq_pkg::LEVELS);
    end

    // Read port A serves the append chain and the query's left window.
    always_comb begin
        if (i_cmd.qry_read) begin
            addr_a = {strmq_pkg::LVL_W'(q_k), r_left};
        end else begin
            addr_a = {r_level, s_next[strmq_pkg::IDX_W-1:0]};
        end
        addr_b  = {strmq_pkg::LVL_W'(q_k), q_second[strmq_pkg::IDX_W-1:0]};
        rd_a_en = (i_cmd.app_write && !app_last) || i_cmd.qry_read;
    end

    // Status to the controller.
    always_comb begin
        o_sts.op       = r_op;
        o_sts.full     = (r_count == strmq_pkg::CNT_W'(strmq_pkg::MAX_ELEMENTS));
        o_sts.bad      = q_bad;
        o_sts.app_last = app_last;
    end

    // Level store: one write port and two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.app_write) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_a_en) begin
            r_rd_a <= mem[addr_a];
        end
        if (i_cmd.qry_read) begin
            r_rd_b <= mem[addr_b];
        end
    end

    // Element count and level counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_level <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_level <= '0;
            end else if (i_cmd.app_write) begin
                r_level <= lvl_next[strmq_pkg::LVL_W-1:0];
            end
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.app_write && app_last) begin
                r_count <= p_plus;
            end
        end
    end

    // Request capture and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_value <= i_value;
            r_left  <= i_left;
            r_right <= i_right;
        end
        if (i_cmd.app_write) begin
            r_last <= wr_data;
        end
        if (i_cmd.res_set) begin
            r_res_min    <= '0;
            r_res_status <= i_cmd.res_status;
        end else if (i_cmd.qry_cmp) begin
            r_res_min    <= (r_rd_b < r_rd_a) ? r_rd_b : r_rd_a;
            r_res_status <= strmq_pkg::ST_OK;
        end
        if (i_cmd.load_out) begin
            r_out_min    <= r_res_min;
            r_out_status <= r_res_status;
            r_out_count  <= r_count;
        end
    end

    assign o_minimum = r_out_min;
    assign o_status  = r_out_status;
    assign o_count   = r_out_count;

    `STRMQ_ASSERT_NOW(a_count_bound, 1'b1,
        r_count <= strmq_pkg::CNT_W'(strmq_pkg::MAX_ELEMENTS))
    `STRMQ_ASSERT_NEXT(a_clear_empties, i_cmd.clear, r_count == '0)
    `STRMQ_ASSERT_NEXT(a_append_counts, i_cmd.app_write && app_last,
        r_count == $past(r_count) + strmq_pkg::CNT_W'(1))

endmodule

// ----- rtl/strmq_ctrl.sv -----
// Controller: sequences append, query and clear requests and the result register.
`include "sparse_table_range_min_macros.svh"

module strmq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    input  strmq_pkg::t_sts i_sts,
    output strmq_pkg::t_cmd o_cmd
);

    strmq_pkg::t_state r_state;
    strmq_pkg::t_state n_state;
    logic              r_out_valid;
    logic              n_out_valid;

    // State and result-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= strmq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            strmq_pkg::S_IDLE: begin
                // No request is taken while reset is held.
                o_s_tready = i_rst_n;
                if (i_s_tvalid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = strmq_pkg::S_DECODE;
                end
            end
            strmq_pkg::S_DECODE: begin
                case (i_sts.op)
                    strmq_pkg::OP_APPEND: begin
                        o_cmd.res_set = 1'b1;
                        if (i_sts.full) begin
                            o_cmd.res_status = strmq_pkg::ST_FULL;
                            n_state          = strmq_pkg::S_FINISH;
                        end else begin
                            o_cmd.res_status = strmq_pkg::ST_OK;
                            o_cmd.app_write  = 1'b1;
                            n_state = i_sts.app_last ? strmq_pkg::S_FINISH
                                                     : strmq_pkg::S_APPEND;
                        end
                    end
                    strmq_pkg::OP_QUERY: begin
                        if (i_sts.bad) begin
                            o_cmd.res_set    = 1'b1;
                            o_cmd.res_status = strmq_pkg::ST_BAD_RANGE;
                            n_state          = strmq_pkg::S_FINISH;
                        end else begin
                            o_cmd.qry_read = 1'b1;
                            n_state        = strmq_pkg::S_QCMP;
                        end
                    end
                    strmq_pkg::OP_CLEAR: begin
                        o_cmd.clear      = 1'b1;
                        o_cmd.res_set    = 1'b1;
                        o_cmd.res_status = strmq_pkg::ST_OK;
                        n_state          = strmq_pkg::S_FINISH;
                    end
                    default: begin
                        o_cmd.res_set    = 1'b1;
                        o_cmd.res_status = strmq_pkg::ST_OK;
                        n_state          = strmq_pkg::S_FINISH;
                    end
                endcase
            end
            strmq_pkg::S_APPEND: begin
                o_cmd.app_write = 1'b1;
                if (i_sts.app_last) begin
                    n_state = strmq_pkg::S_FINISH;
                end
            end
            strmq_pkg::S_QCMP: begin
                o_cmd.qry_cmp = 1'b1;
                n_state       = strmq_pkg::S_FINISH;
            end
            strmq_pkg::S_FINISH: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = strmq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = strmq_pkg::S_IDLE;
            end
        endcase
    end

    // The result register fills on load and empties when taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;

    `STRMQ_ASSERT_NEXT(a_capture_decodes, o_cmd.capture, r_state == strmq_pkg::S_DECODE)
    `STRMQ_ASSERT_NEXT(a_load_shows, o_cmd.load_out, r_out_valid)
    `STRMQ_ASSERT_NOW(a_qcmp_after_decode, r_state == strmq_pkg::S_QCMP,
        $past(r_state) == strmq_pkg::S_DECODE)

endmodule

// ----- rtl/sparse_table_range_min.sv -----
// Range-minimum block over an incrementally built sparse table.
// Requests enter on the slave stream: tuser carries the operation (append,
// query, clear), tdata the value to append and the query range [left, right).
// Each request gives exactly one result on the master stream: tdata holds the
// minimum and the element count after the request, tuser the status.
// One request is worked on at a time; tready is high only between requests.
// An append writes every level whose window ends at the new element (1 to
// 11 levels), one level per cycle through the level store's single write
// port; a full table append writes nothing. A query makes two registered
// reads of the store, then one compare. A clear or a bad range goes straight
// to the result.
// The finished result waits in an output register, so a stalled receiver
// holds only that register: the next request is accepted and worked on, and
// it waits before loading its own result until the register is taken.
// Synchronous reset empties the table and drops any pending result; the
// store's contents are not cleared, as a query only reads entries written
// since the last clear.
module sparse_table_range_min (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // value [63:0], left [73:64], right [84:74], zero pad above
    input  logic [strmq_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // op [1:0]
    input  logic [strmq_pkg::OP_W-1:0]         i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // minimum [63:0], loaded_count [74:64], zero pad above
    output logic [strmq_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    // status [1:0]
    output logic [strmq_pkg::STATUS_W-1:0]     o_m_axis_tuser
);

    localparam int LEFT_LO  = strmq_pkg::DATA_W;
    localparam int RIGHT_LO = strmq_pkg::DATA_W + strmq_pkg::IDX_W;
    localparam int S_USED   = RIGHT_LO + strmq_pkg::CNT_W;
    localparam int M_USED   = strmq_pkg::DATA_W + strmq_pkg::CNT_W;

    strmq_pkg::t_cmd                     cmd;
    strmq_pkg::t_sts                     sts;
    logic signed [strmq_pkg::DATA_W-1:0] minimum;
    logic [strmq_pkg::STATUS_W-1:0]      status;
    logic [strmq_pkg::CNT_W-1:0]         loaded_count;

    strmq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    strmq_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_op      (i_s_axis_tuser),
        .i_value   (i_s_axis_tdata[strmq_pkg::DATA_W-1:0]),
        .i_left    (i_s_axis_tdata[RIGHT_LO-1:LEFT_LO]),
        .i_right   (i_s_axis_tdata[S_USED-1:RIGHT_LO]),
        .o_minimum (minimum),
        .o_status  (status),
        .o_count   (loaded_count)
    );

    // Pack the result fields, lowest field first.
    assign o_m_axis_tdata = {{(strmq_pkg::M_TDATA_W - M_USED){1'b0}}, loaded_count, minimum};
    assign o_m_axis_tuser = status;

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the sparse-table range-minimum block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import strmq_pkg::*;

    // The op code the block leaves unused.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_LIMIT   = 4000;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 20;

    typedef struct {
        logic [DATA_W-1:0] minimum;
        t_status           status;
        logic [CNT_W-1:0]  count;
    } t_range_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic [S_TDATA_W-1:0] s_data = '0;
    logic [OP_W-1:0]      s_user = '0;
    logic                 m_ready = 1'b0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic [STATUS_W-1:0]  o_m_axis_tuser;

    // Shadow copy of the table and the element count.
    logic signed [DATA_W-1:0] level_copy [LEVELS][MAX_ELEMENTS];
    int unsigned              held_count = 0;
    t_range_result            pending_results [$];

    int error_count = 0;
    int burst_left = 0;
    int stall_orders = 0;
    int stall_served = 0;
    int hold_left = 0;
    int ready_mode = 0;
    int mode_left = 0;
    int idle_cycles = 0;

    sparse_table_range_min u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Works out the result of one accepted request and updates the shadow table.
    function automatic void predict_table_result(input logic [OP_W-1:0] op,
                                                 input logic signed [DATA_W-1:0] value,
                                                 input logic [IDX_W-1:0] left,
                                                 input logic [CNT_W-1:0] right);
        t_range_result            res;
        int unsigned              pos;
        int unsigned              start;
        int unsigned              span;
        int unsigned              k;
        logic [31:0]              len;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        res.minimum = '0;
        res.status  = ST_OK;
        case (op)
            OP_APPEND: begin
                if (held_count >= MAX_ELEMENTS) begin
                    res.status = ST_FULL;
                end else begin
                    pos = held_count;
                    level_copy[0][pos] = value;
                    // Every level whose window now ends at the new element.
                    for (int j = 1; j < LEVELS; j++) begin
                        span = 1 << j;
                        if (pos + 1 < span) break;
                        start = pos + 1 - span;
                        a = level_copy[j-1][start];
                        b = level_copy[j-1][start + span / 2];
                        level_copy[j][start] = (b < a) ? b : a;
                    end
                    held_count = pos + 1;
                end
            end
            OP_QUERY: begin
                if (left >= right || right > held_count) begin
                    res.status = ST_BAD_RANGE;
                end else begin
                    len = right - left;
                    k = 0;
                    for (int i = 0; i < 32; i++) begin
                        if (len[i]) k = i;
                    end
                    if (k >= LEVELS) begin
                        res.status = ST_BAD_RANGE;
                    end else begin
                        a = level_copy[k][left];
                        b = level_copy[k][right - (1 << k)];
                        res.minimum = (b < a) ? b : a;
                    end
                end
            end
            OP_CLEAR: begin
                held_count = 0;
            end
            default: begin
            end
        endcase
        res.count = CNT_W'(held_count);
        pending_results.push_back(res);
    endfunction

    // Mostly random bit patterns, with the extremes and small values for ties.
    function automatic logic [DATA_W-1:0] random_value();
        logic [3:0] nib;
        nib = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2, 3: return {{60{nib[3]}}, nib};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Picks a query range: mostly valid for the current count, some random.
    task automatic pick_range(output logic [IDX_W-1:0] l, output logic [CNT_W-1:0] r);
        int unsigned k;
        if (held_count == 0 || $urandom_range(0, 9) == 0) begin
            l = IDX_W'($urandom_range(0, MAX_ELEMENTS - 1));
            r = CNT_W'($urandom_range(1, MAX_ELEMENTS));
        end else begin
            r = CNT_W'($urandom_range(1, held_count));
            if ($urandom_range(0, 3) == 0) begin
                // Length of an exact power of two.
                k = 0;
                while ((2 << k) <= r) k++;
                k = $urandom_range(0, k);
                l = IDX_W'(r - (1 << k));
            end else begin
                l = IDX_W'($urandom_range(0, r - 1));
            end
        end
    endtask

    // Offers one request in bursts with random gaps and waits for acceptance.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
                                input logic [IDX_W-1:0] left, input logic [CNT_W-1:0] right);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
        end
        repeat (gap) begin
            @(negedge i_clk);
            s_valid <= 1'b0;
        end
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {{(S_TDATA_W - DATA_W - IDX_W - CNT_W){1'b0}}, right, left, value};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_table_result(op, value, left, right);
        burst_left--;
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_all_results();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic test_directed_edges();
        send_request(OP_QUERY, '0, 10'd0, 11'd1);
        send_request(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 10'd1023, 11'd1024);
        send_request(OP_APPEND, 64'h8000_0000_0000_0000, '0, '0);
        send_request(OP_APPEND, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0);
        send_request(OP_APPEND, 64'h0, '0, '0);
        send_request(OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
        send_request(OP_APPEND, 64'd7, '0, '0);
        send_request(OP_QUERY, '0, 10'd0, 11'd5);
        send_request(OP_QUERY, '0, 10'd1, 11'd2);
        send_request(OP_QUERY, '0, 10'd1, 11'd4);
        send_request(OP_QUERY, '0, 10'd2, 11'd5);
        send_request(OP_QUERY, '0, 10'd4, 11'd5);
        // Bad ranges: empty, reversed, past the count, far past the count.
        send_request(OP_QUERY, '0, 10'd3, 11'd3);
        send_request(OP_QUERY, '0, 10'd4, 11'd2);
        send_request(OP_QUERY, '0, 10'd0, 11'd6);
        send_request(OP_QUERY, '0, 10'd1023, 11'd1024);
        // A clear leaves nothing to query.
        send_request(OP_CLEAR, '0, '0, '0);
        send_request(OP_QUERY, '0, 10'd0, 11'd1);
        send_request(OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
        send_request(OP_APPEND, 64'd1, '0, '0);
        send_request(OP_QUERY, '0, 10'd0, 11'd2);
        send_request(OP_CLEAR, '0, '0, '0);
    endtask

    // Builds the table up to capacity with queries mixed in, then probes it full.
    task automatic test_fill_to_capacity();
        logic [IDX_W-1:0] l;
        logic [CNT_W-1:0] r;
        while (held_count < MAX_ELEMENTS) begin
            if ($urandom_range(0, 19) == 0) begin
                pick_range(l, r);
                send_request(OP_QUERY, '0, l, r);
            end else begin
                send_request(OP_APPEND, random_value(), '0, '0);
            end
        end
        send_request(OP_APPEND, random_value(), '0, '0);
        send_request(OP_QUERY, '0, 10'd0, 11'd1024);
        send_request(OP_QUERY, '0, 10'd1023, 11'd1024);
        send_request(OP_QUERY, '0, 10'd512, 11'd1024);
        send_request(OP_QUERY, '0, 10'd0, 11'd1023);
        repeat (36) begin
            if ($urandom_range(0, 3) == 0) begin
                send_request(OP_APPEND, random_value(), '0, '0);
            end else begin
                pick_range(l, r);
                send_request(OP_QUERY, '0, l, r);
            end
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_receiver_hold();
        logic [IDX_W-1:0] l;
        logic [CNT_W-1:0] r;
        @(negedge i_clk);
        stall_orders++;
        repeat (24) begin
            pick_range(l, r);
            send_request(OP_QUERY, '0, l, r);
        end
        wait_all_results();
    endtask

    // Small tables with every operation mixed in at random.
    task automatic test_random_mix();
        logic [IDX_W-1:0] l;
        logic [CNT_W-1:0] r;
        int               pick;
        send_request(OP_CLEAR, '0, '0, '0);
        repeat (40) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_request(OP_APPEND, random_value(), '0, '0);
            end else if (pick < 94) begin
                pick_range(l, r);
                send_request(OP_QUERY, '0, l, r);
            end else if (pick < 98) begin
                send_request(OP_CLEAR, '0, '0, '0);
            end else begin
                pick_range(l, r);
                send_request(OP_UNUSED, random_value(), l, r);
            end
        end
    endtask

    // Receiver ready pattern, with a long hold-off when a test orders one.
    always @(negedge i_clk) begin
        if (stall_served != stall_orders) begin
            stall_served = stall_orders;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (ready_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_range_result want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual tdata %h tuser %h",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata[DATA_W-1:0] !== want.minimum) begin
                    $display("%0t: minimum mismatch: expected %h, actual %h",
                             $time, want.minimum, o_m_axis_tdata[DATA_W-1:0]);
                    error_count++;
                end
                if (o_m_axis_tuser !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, o_m_axis_tuser);
                    error_count++;
                end
                if (o_m_axis_tdata[DATA_W+CNT_W-1:DATA_W] !== want.count) begin
                    $display("%0t: loaded_count mismatch: expected %0d, actual %0d",
                             $time, want.count, o_m_axis_tdata[DATA_W+CNT_W-1:DATA_W]);
                    error_count++;
                end
            end
        end
    end

    // Ends a run in which nothing moves on either stream for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_edges();
        test_fill_to_capacity();
        test_receiver_hold();
        test_random_mix();
        wait_all_results();
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
